// File: rtl/windowed_access_feature_normalizer_defines.svh
// Assertion shorthands for the feature normalizer checker.
`ifndef WINDOWED_ACCESS_FEATURE_NORMALIZER_DEFINES_SVH
`define WINDOWED_ACCESS_FEATURE_NORMALIZER_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define WAFN_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset.
`define WAFN_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/wafn_pkg.sv
package wafn_pkg;

    localparam int FEATURE_COUNT = 5;
    localparam int FEAT_IDX_W    = 3;
    localparam int IN_DATA_W     = 120;
    localparam int OUT_DATA_W    = 128;
    localparam int OUT_USER_W    = 5;

    localparam logic [FEAT_IDX_W-1:0] FEAT_LAST = 3'd4;

    localparam logic [63:0] MAX63 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MIN63 = 64'h8000_0000_0000_0000;

    localparam logic [31:0] WINDOW_LEN_RESET = 32'd1000000000;
    localparam logic [31:0] PAGE_LIMIT_RESET = 32'd1000000;

    // configuration register indexes
    localparam logic [1:0] REG_WINDOW_LEN = 2'd0;
    localparam logic [1:0] REG_PAGE_LIMIT = 2'd1;
    localparam logic [1:0] REG_APPLY      = 2'd2;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_DIV,
        ALU_SQRT
    } alu_op_t;

    typedef struct packed {
        alu_op_t      op;
        logic [127:0] a;
        logic [63:0]  b;
    } alu_cmd_t;

endpackage

// File: rtl/windowed_access_feature_normalizer.sv
// A command or dropped access goes to S_IDLE_OUT, which loads its result once the output is
// free; a kept access updates mean and M2 first; a window close fills features in S_C0-S_C5,
// then runs S_F0-S_F7 and S_EMIT per feature (the last division skipped on zero deviation).
// Throughput: one input at a time; s_tready is high only while the sequencer is idle.
// One shared unit does every division, square root and product, one command at a time.
// Reset (aresetn low, synchronous) clears all statistics and loads the register defaults.
module windowed_access_feature_normalizer #(
    parameter int FRAC_BITS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // time_ns[62:0], page_index[94:63], readahead[114:95]
    input  logic [wafn_pkg::IN_DATA_W-1:0]    s_tdata,
    // kind[0]
    input  logic [0:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // raw_feature[63:0], normalized_feature[127:64]
    output logic [wafn_pkg::OUT_DATA_W-1:0]   m_tdata,
    // window_closed[0], feature_index[3:1], divide_flag[4]
    output logic [wafn_pkg::OUT_USER_W-1:0]   m_tuser,
    output logic                              m_tlast,
    input  logic                              cfg_wr_en,
    input  logic [1:0]                        cfg_index,
    input  logic [31:0]                       cfg_wdata
);
    import wafn_pkg::*;

    localparam int          M2_SHIFT = 2 * FRAC_BITS - 8;
    localparam int          X_SHIFT  = FRAC_BITS - 8;
    localparam int          RA_SHIFT = FRAC_BITS - 10;
    localparam logic [63:0] F0_LIMIT = MAX63 >> FRAC_BITS;

    typedef enum logic [4:0] {
        S_IDLE, S_WAIT, S_W_MEAN, S_W_D2, S_W_M2,
        S_C0, S_C1, S_C2, S_C3, S_C4, S_C5,
        S_F0, S_F1, S_F2, S_F3, S_F4, S_F5, S_F6, S_F7,
        S_EMIT, S_IDLE_OUT
    } state_t;

    state_t state_reg;
    state_t ret_reg;

    logic [31:0] wl_reg;
    logic [31:0] limit_reg;
    logic        apply_reg;

    logic [62:0] ws_reg;
    logic [31:0] count_reg;
    logic [63:0] mean_reg;
    logic [63:0] m2_reg;
    logic [31:0] min_reg;
    logic [31:0] max_reg;
    logic [31:0] prev_page_reg;
    logic        prev_ok_reg;
    logic [63:0] jump_reg;
    logic [31:0] wn_reg;
    logic [63:0] fmean_reg [FEATURE_COUNT];
    logic [63:0] fvar_reg  [FEATURE_COUNT];
    logic [63:0] fprev_reg [FEATURE_COUNT];

    logic [63:0] feat_reg [FEATURE_COUNT];
    logic        flag_reg [FEATURE_COUNT];
    logic [FEAT_IDX_W-1:0] i_reg;
    logic [62:0]  t_reg;
    logic [31:0]  page_reg;
    logic [19:0]  ra_reg;
    logic         pos_reg;
    logic [63:0]  d_reg;
    logic [127:0] acc_reg;
    logic [63:0]  mean_tmp_reg;
    logic [63:0]  var_tmp_reg;
    logic [63:0]  q_reg;
    logic         neg_reg;

    logic        start_reg;
    alu_cmd_t    cmd_reg;
    logic        alu_done;
    logic [127:0] alu_res;

    logic        m_tvalid_reg;
    logic        out_wc_reg;
    logic [FEAT_IDX_W-1:0] out_idx_reg;
    logic [63:0] out_raw_reg;
    logic [63:0] out_norm_reg;
    logic        out_flag_reg;
    logic        out_last_reg;

    logic [62:0]  in_time;
    logic [31:0]  in_page;
    logic [19:0]  in_ra;
    logic         in_kind;
    logic         accept;
    logic         out_free;
    logic         out_load;
    logic [31:0]  count_inc;
    logic [63:0]  p_in;
    logic         p_ge;
    logic [63:0]  d_in;
    logic [31:0]  jd;
    logic [64:0]  jsum;
    logic [63:0]  p_cur;
    logic [63:0]  d2;
    logic [127:0] m2w;
    logic [64:0]  m2_sum;
    logic         win_close;
    logic [31:0]  range;
    logic [127:0] x_wide;
    logic [63:0]  qsat;
    logic [63:0]  feat_i;
    logic [63:0]  prev_i;
    logic [63:0]  diff_f;
    logic [31:0]  wn_dec;
    logic         neg;
    logic [63:0]  diffm;

    function automatic alu_cmd_t mk_cmd(alu_op_t op, logic [127:0] a, logic [63:0] b);
        alu_cmd_t c;
        c.op = op;
        c.a  = a;
        c.b  = b;
        return c;
    endfunction

    assign in_time = s_tdata[62:0];
    assign in_page = s_tdata[94:63];
    assign in_ra   = s_tdata[114:95];
    assign in_kind = s_tuser[0];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = out_free && ((state_reg == S_EMIT) || (state_reg == S_IDLE_OUT));

    assign count_inc = (count_reg == 32'hFFFF_FFFF) ? count_reg : count_reg + 32'd1;
    assign p_in      = {32'b0, in_page} << FRAC_BITS;
    assign p_ge      = p_in >= mean_reg;
    assign d_in      = p_ge ? p_in - mean_reg : mean_reg - p_in;
    assign jd        = (in_page > prev_page_reg) ? in_page - prev_page_reg
                                                 : prev_page_reg - in_page;
    assign jsum      = {1'b0, jump_reg} + {33'b0, jd};

    assign p_cur  = {32'b0, page_reg} << FRAC_BITS;
    assign d2     = pos_reg ? p_cur - mean_reg : mean_reg - p_cur;
    assign m2w    = alu_res >> M2_SHIFT;
    assign m2_sum = {1'b0, m2_reg} + {1'b0, m2w[63:0]};
    assign win_close = (t_reg > ws_reg) && ((t_reg - ws_reg) > {31'b0, wl_reg});

    assign range  = max_reg - min_reg;
    assign x_wide = {64'b0, m2_reg} << X_SHIFT;

    // zero divisor: zero over zero is zero, anything else saturates
    assign qsat = (cmd_reg.b == 64'd0) ? ((cmd_reg.a == 128'd0) ? 64'd0 : MAX63)
                : ((alu_res[127:63] != 65'd0) ? MAX63 : alu_res[63:0]);

    assign feat_i = feat_reg[i_reg];
    assign prev_i = fprev_reg[i_reg];
    assign diff_f = (feat_i >= prev_i) ? feat_i - prev_i : prev_i - feat_i;
    assign wn_dec = wn_reg - 32'd1;
    assign neg    = feat_i < mean_tmp_reg;
    assign diffm  = neg ? mean_tmp_reg - feat_i : feat_i - mean_tmp_reg;

    wafn_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .cmd     (cmd_reg),
        .done    (alu_done),
        .res     (alu_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            start_reg     <= 1'b0;
            wl_reg        <= WINDOW_LEN_RESET;
            limit_reg     <= PAGE_LIMIT_RESET;
            apply_reg     <= 1'b1;
            ws_reg        <= '0;
            count_reg     <= '0;
            mean_reg      <= '0;
            m2_reg        <= '0;
            min_reg       <= '1;
            max_reg       <= '0;
            prev_page_reg <= '0;
            prev_ok_reg   <= 1'b0;
            jump_reg      <= '0;
            wn_reg        <= '0;
            i_reg         <= '0;
            m_tvalid_reg  <= 1'b0;
            for (int k = 0; k < FEATURE_COUNT; k++) begin
                fmean_reg[k] <= '0;
                fvar_reg[k]  <= '0;
                fprev_reg[k] <= '0;
            end
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_WINDOW_LEN: wl_reg    <= cfg_wdata;
                    REG_PAGE_LIMIT: limit_reg <= cfg_wdata;
                    REG_APPLY:      apply_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        t_reg    <= in_time;
                        page_reg <= in_page;
                        ra_reg   <= in_ra;
                        if (in_kind) begin
                            ws_reg    <= '0;
                            state_reg <= S_IDLE_OUT;
                        end else begin
                            if (count_reg == 32'd0) begin
                                ws_reg <= in_time;
                            end
                            if (in_page > limit_reg) begin
                                state_reg <= S_IDLE_OUT;
                            end else begin
                                count_reg <= count_inc;
                                if (prev_ok_reg) begin
                                    jump_reg <= jsum[64] ? '1 : jsum[63:0];
                                end
                                prev_page_reg <= in_page;
                                prev_ok_reg   <= 1'b1;
                                if (in_page < min_reg) min_reg <= in_page;
                                if (in_page > max_reg) max_reg <= in_page;
                                pos_reg   <= p_ge;
                                d_reg     <= d_in;
                                cmd_reg   <= mk_cmd(ALU_DIV, {64'b0, d_in}, {32'b0, count_inc});
                                start_reg <= 1'b1;
                                ret_reg   <= S_W_MEAN;
                                state_reg <= S_WAIT;
                            end
                        end
                    end
                end
                S_WAIT: begin
                    start_reg <= 1'b0;
                    if (alu_done) begin
                        state_reg <= ret_reg;
                    end
                end
                S_W_MEAN: begin
                    mean_reg  <= pos_reg ? mean_reg + alu_res[63:0] : mean_reg - alu_res[63:0];
                    state_reg <= S_W_D2;
                end
                S_W_D2: begin
                    cmd_reg   <= mk_cmd(ALU_MUL, {64'b0, d_reg}, d2);
                    start_reg <= 1'b1;
                    ret_reg   <= S_W_M2;
                    state_reg <= S_WAIT;
                end
                S_W_M2: begin
                    m2_reg <= ((m2w[127:64] != 64'd0) || m2_sum[64]) ? '1 : m2_sum[63:0];
                    state_reg <= win_close ? S_C0 : S_IDLE_OUT;
                end
                S_C0: begin
                    feat_reg[0] <= ({32'b0, count_reg} <= F0_LIMIT)
                                   ? ({32'b0, count_reg} << FRAC_BITS) : MAX63;
                    feat_reg[4] <= {44'b0, ra_reg} << RA_SHIFT;
                    for (int k = 0; k < FEATURE_COUNT; k++) begin
                        flag_reg[k] <= 1'b0;
                    end
                    cmd_reg   <= mk_cmd(ALU_MUL, {96'b0, count_reg}, {32'b0, range});
                    start_reg <= 1'b1;
                    ret_reg   <= S_C1;
                    state_reg <= S_WAIT;
                end
                S_C1: begin
                    cmd_reg   <= mk_cmd(ALU_DIV, x_wide, alu_res[63:0]);
                    start_reg <= 1'b1;
                    ret_reg   <= S_C2;
                    state_reg <= S_WAIT;
                end
                S_C2: begin
                    feat_reg[1] <= qsat;
                    flag_reg[1] <= (cmd_reg.b == 64'd0);
                    cmd_reg     <= mk_cmd(ALU_MUL, {96'b0, count_reg - 32'd1}, {32'b0, range});
                    start_reg   <= 1'b1;
                    ret_reg     <= S_C3;
                    state_reg   <= S_WAIT;
                end
                S_C3: begin
                    cmd_reg   <= mk_cmd(ALU_DIV, x_wide, alu_res[63:0]);
                    start_reg <= 1'b1;
                    ret_reg   <= S_C4;
                    state_reg <= S_WAIT;
                end
                S_C4: begin
                    feat_reg[2] <= qsat;
                    flag_reg[2] <= (cmd_reg.b == 64'd0);
                    cmd_reg     <= mk_cmd(ALU_DIV, {64'b0, jump_reg} << FRAC_BITS,
                                          {32'b0, count_reg});
                    start_reg   <= 1'b1;
                    ret_reg     <= S_C5;
                    state_reg   <= S_WAIT;
                end
                S_C5: begin
                    feat_reg[3] <= qsat;
                    flag_reg[3] <= (cmd_reg.b == 64'd0);
                    if (wn_reg != 32'hFFFF_FFFF) begin
                        wn_reg <= wn_reg + 32'd1;
                    end
                    i_reg     <= '0;
                    state_reg <= S_F0;
                end
                S_F0: begin
                    cmd_reg   <= mk_cmd(ALU_MUL, {64'b0, fmean_reg[i_reg]}, {32'b0, wn_dec});
                    start_reg <= 1'b1;
                    ret_reg   <= S_F1;
                    state_reg <= S_WAIT;
                end
                S_F1: begin
                    cmd_reg   <= mk_cmd(ALU_DIV, alu_res + {64'b0, feat_i}, {32'b0, wn_reg});
                    start_reg <= 1'b1;
                    ret_reg   <= S_F2;
                    state_reg <= S_WAIT;
                end
                S_F2: begin
                    mean_tmp_reg <= qsat;
                    cmd_reg      <= mk_cmd(ALU_MUL, {64'b0, diff_f}, diff_f);
                    start_reg    <= 1'b1;
                    ret_reg      <= S_F3;
                    state_reg    <= S_WAIT;
                end
                S_F3: begin
                    acc_reg   <= alu_res >> FRAC_BITS;
                    cmd_reg   <= mk_cmd(ALU_MUL, {64'b0, fvar_reg[i_reg]}, {32'b0, wn_dec});
                    start_reg <= 1'b1;
                    ret_reg   <= S_F4;
                    state_reg <= S_WAIT;
                end
                S_F4: begin
                    cmd_reg   <= mk_cmd(ALU_DIV, acc_reg + alu_res, {32'b0, wn_reg});
                    start_reg <= 1'b1;
                    ret_reg   <= S_F5;
                    state_reg <= S_WAIT;
                end
                S_F5: begin
                    var_tmp_reg <= qsat;
                    cmd_reg     <= mk_cmd(ALU_SQRT, {64'b0, qsat} << FRAC_BITS, 64'd0);
                    start_reg   <= 1'b1;
                    ret_reg     <= S_F6;
                    state_reg   <= S_WAIT;
                end
                S_F6: begin
                    if (alu_res[63:0] == 64'd0) begin
                        // zero deviation: zero if the feature equals the mean, else saturate by sign
                        flag_reg[i_reg] <= 1'b1;
                        q_reg <= (diffm == 64'd0) ? 64'd0 : (neg ? MIN63 : MAX63);
                        state_reg <= S_EMIT;
                    end else begin
                        neg_reg   <= neg;
                        cmd_reg   <= mk_cmd(ALU_DIV, {64'b0, diffm} << FRAC_BITS,
                                            alu_res[63:0]);
                        start_reg <= 1'b1;
                        ret_reg   <= S_F7;
                        state_reg <= S_WAIT;
                    end
                end
                S_F7: begin
                    if (neg_reg) begin
                        q_reg <= (qsat == MAX63) ? MIN63 : (~qsat + 64'd1);
                    end else begin
                        q_reg <= qsat;
                    end
                    state_reg <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        out_wc_reg       <= 1'b1;
                        out_idx_reg      <= i_reg;
                        out_raw_reg      <= feat_i;
                        out_norm_reg     <= q_reg;
                        out_flag_reg     <= flag_reg[i_reg];
                        out_last_reg     <= (i_reg == FEAT_LAST);
                        fprev_reg[i_reg] <= feat_i;
                        if (apply_reg) begin
                            fmean_reg[i_reg] <= mean_tmp_reg;
                            fvar_reg[i_reg]  <= var_tmp_reg;
                        end
                        if (i_reg == FEAT_LAST) begin
                            // restart the window at this access
                            count_reg   <= '0;
                            mean_reg    <= '0;
                            m2_reg      <= '0;
                            min_reg     <= '1;
                            max_reg     <= '0;
                            jump_reg    <= '0;
                            prev_ok_reg <= 1'b0;
                            ws_reg      <= t_reg;
                            state_reg   <= S_IDLE;
                        end else begin
                            i_reg     <= i_reg + 3'd1;
                            state_reg <= S_F0;
                        end
                    end
                end
                S_IDLE_OUT: begin
                    if (out_free) begin
                        out_wc_reg   <= 1'b0;
                        out_idx_reg  <= '0;
                        out_raw_reg  <= '0;
                        out_norm_reg <= '0;
                        out_flag_reg <= 1'b0;
                        out_last_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_norm_reg, out_raw_reg};
    assign m_tuser  = {out_flag_reg, out_idx_reg, out_wc_reg};
    assign m_tlast  = out_last_reg;

endmodule

// File: rtl/wafn_alu.sv
module wafn_alu (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  wafn_pkg::alu_cmd_t cmd,
    output logic               done,
    output logic [127:0]       res
);
    import wafn_pkg::*;

    alu_op_t      op_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [7:0]   cnt_reg;
    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [127:0] acc_reg;
    logic [65:0]  rem_reg;
    logic [63:0]  root_reg;
    logic [63:0]  prod_reg;

    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [63:0]  prod_next;
    logic [127:0] mul_term;
    logic [64:0]  div_sh;
    logic         div_ge;
    logic [64:0]  div_sub;
    logic [67:0]  sq_sh;
    logic [67:0]  sq_trial;
    logic         sq_ge;
    logic [67:0]  sq_sub;
    logic [7:0]   last_cnt;

    // partial products in order low*low, low*high, high*low, high*high
    assign a_half    = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign b_half    = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
    assign prod_next = a_half * b_half;

    always_comb begin
        unique case (cnt_reg[2:0])
            3'd2, 3'd3: mul_term = {64'b0, prod_reg} << 32;
            3'd4:       mul_term = {64'b0, prod_reg} << 64;
            default:    mul_term = {64'b0, prod_reg};
        endcase
    end

    // restoring division, one quotient bit a cycle
    assign div_sh  = {rem_reg[63:0], acc_reg[127]};
    assign div_ge  = div_sh >= {1'b0, b_reg};
    assign div_sub = div_sh - {1'b0, b_reg};

    // digit-by-digit square root, two radicand bits a cycle
    assign sq_sh    = {rem_reg, acc_reg[127:126]};
    assign sq_trial = {2'b0, root_reg, 2'b01};
    assign sq_ge    = sq_sh >= sq_trial;
    assign sq_sub   = sq_sh - sq_trial;

    always_comb begin
        unique case (op_reg)
            ALU_MUL:  last_cnt = 8'd4;
            ALU_DIV:  last_cnt = 8'd127;
            ALU_SQRT: last_cnt = 8'd63;
            default:  last_cnt = 8'd4;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= ALU_MUL;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                op_reg   <= cmd.op;
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 8'd1;
                if (cnt_reg == last_cnt) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg    <= cmd.a[63:0];
            b_reg    <= cmd.b;
            acc_reg  <= (cmd.op == ALU_MUL) ? '0 : cmd.a;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            unique case (op_reg)
                ALU_MUL: begin
                    if (cnt_reg != 8'd4) begin
                        prod_reg <= prod_next;
                    end
                    if (cnt_reg != 8'd0) begin
                        acc_reg <= acc_reg + mul_term;
                    end
                end
                ALU_DIV: begin
                    rem_reg <= {2'b0, (div_ge ? div_sub[63:0] : div_sh[63:0])};
                    acc_reg <= {acc_reg[126:0], div_ge};
                end
                ALU_SQRT: begin
                    rem_reg  <= sq_ge ? sq_sub[65:0] : sq_sh[65:0];
                    root_reg <= {root_reg[62:0], sq_ge};
                    acc_reg  <= {acc_reg[125:0], 2'b00};
                end
                default: ;
            endcase
        end
    end

    assign done = done_reg;
    assign res  = (op_reg == ALU_SQRT) ? {64'b0, root_reg} : acc_reg;

endmodule

// File: rtl/wafn_checker.sv
`include "windowed_access_feature_normalizer_defines.svh"

module wafn_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [wafn_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [wafn_pkg::OUT_USER_W-1:0] m_tuser,
    input logic                            m_tlast
);
    import wafn_pkg::*;

    `WAFN_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")
    `WAFN_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "input taken while busy")
    `WAFN_ASSERT_IMP(a_plain_result, m_tvalid && !m_tuser[0], m_tlast && (m_tdata == '0) && (m_tuser == '0), "non-close result not empty")
    `WAFN_ASSERT_IMP(a_last_feature, m_tvalid && m_tuser[0], m_tlast == (m_tuser[3:1] == FEAT_LAST), "tlast not on final feature")

endmodule

bind windowed_access_feature_normalizer wafn_checker u_wafn_checker (.*);
